// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the heat stress rank blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define HSPR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define HSPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HSPR_ASSERT(label, clk, rstn, prop)
`define HSPR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/hspr_pkg.sv
// ----------------------------------------------------------------------------
// hspr_pkg
// shared types, widths and defaults of the heat stress percentile rank block
// ----------------------------------------------------------------------------
`default_nettype none

package hspr_pkg;

    // defaults for the top level parameters
    localparam int TABLE_ENTRIES_DEF = 98;
    localparam int WINDOW_LENGTH_DEF = 8;

    // fixed field widths
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 16;
    localparam int RANK_W  = 8;

    // mode field codes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // rank reported while the window is still filling
    localparam logic [RANK_W-1:0] RANK_FILLING = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_FIX,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_PUSH
    } hspr_state_t;

    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic abs_step;   // split window sum into sign and magnitude
        logic mul_step;   // reciprocal multiply of the magnitude
        logic fix_step;   // quotient correction, mean, search init
        logic probe_rd;   // issue table read at the search midpoint
        logic probe_cmp;  // compare mean with the table entry read
        logic push;       // load the output register
    } hspr_cmd_t;

    typedef struct packed {
        logic sample_mode;  // input item is a temperature sample
        logic filling;      // input sample falls inside the fill phase
        logic search_open;  // search interval not yet empty
        logic out_full;     // output register holds an untaken result
    } hspr_stat_t;

endpackage

`default_nettype wire

// File: rtl/hspr_ram.sv
// ----------------------------------------------------------------------------
// hspr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module hspr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 98
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/hspr_ctrl.sv
// ----------------------------------------------------------------------------
// hspr_ctrl
// sequencer for window update, mean division and binary search
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hspr_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire hspr_pkg::hspr_stat_t  stat,
    output hspr_pkg::hspr_cmd_t        cmd
);

    import hspr_pkg::*;

    hspr_state_t state_reg;
    hspr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.sample_mode) begin
                    state_next = stat.filling ? ST_PUSH : ST_ABS;
                end
            end
            ST_ABS:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_FIX;
            ST_FIX:       state_next = ST_PROBE_RD;
            ST_PROBE_RD: begin
                state_next = stat.search_open ? ST_PROBE_CMP : ST_PUSH;
            end
            ST_PROBE_CMP: state_next = ST_PROBE_RD;
            ST_PUSH: begin
                if (!stat.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_ABS:       cmd.abs_step  = 1'b1;
            ST_MUL:       cmd.mul_step  = 1'b1;
            ST_FIX:       cmd.fix_step  = 1'b1;
            ST_PROBE_RD:  cmd.probe_rd  = stat.search_open;
            ST_PROBE_CMP: cmd.probe_cmp = 1'b1;
            ST_PUSH:      cmd.push      = !stat.out_full;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    `HSPR_ASSERT(a_cmp_follows_rd, aclk, aresetn, (state_reg == ST_PROBE_CMP) |-> ($past(state_reg) == ST_PROBE_RD))
    `HSPR_ASSERT_NEXT(a_sample_leaves_idle, aclk, aresetn, cmd.take && stat.sample_mode, state_reg != ST_IDLE)
    `HSPR_ASSERT_NEXT(a_load_stays_idle, aclk, aresetn, cmd.take && !stat.sample_mode, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// File: rtl/hspr_dpath.sv
// ----------------------------------------------------------------------------
// hspr_dpath
// sample window, running sum, divide by window length, table search
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hspr_dpath #(
    parameter int TABLE_ENTRIES = hspr_pkg::TABLE_ENTRIES_DEF,
    parameter int WINDOW_LENGTH = hspr_pkg::WINDOW_LENGTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_mode,
    input  wire logic                                  s_series_start,
    input  wire logic        [hspr_pkg::INDEX_W-1:0]   s_table_index,
    input  wire logic signed [hspr_pkg::VALUE_W-1:0]   s_threshold_value,
    input  wire logic signed [hspr_pkg::VALUE_W-1:0]   s_temperature,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed      [hspr_pkg::RANK_W-1:0]    m_rank,
    output logic signed      [hspr_pkg::VALUE_W-1:0]   m_window_mean,
    input  wire hspr_pkg::hspr_cmd_t                   cmd,
    output hspr_pkg::hspr_stat_t                       stat
);

    import hspr_pkg::*;

    localparam int SW   = VALUE_W + $clog2(WINDOW_LENGTH);  // sum width
    localparam int FW   = $clog2(WINDOW_LENGTH);
    localparam int TAW  = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FW-1:0] FILL_TOP = FW'(WINDOW_LENGTH - 1);
    localparam logic [SW-1:0] RECIP    = SW'((64'd1 << SW) / WINDOW_LENGTH);
    localparam logic [SW-1:0] WLEN     = SW'(WINDOW_LENGTH);
    localparam logic [CW-1:0] TOP      = CW'(TABLE_ENTRIES);

    // window and running sum
    logic                      is_sample;
    logic signed [VALUE_W-1:0] win_reg [WINDOW_LENGTH];
    logic signed [SW-1:0]      sum_reg;
    logic signed [SW-1:0]      sum_next;
    logic [FW-1:0]             fill_reg;
    logic [FW-1:0]             fill_eff;
    logic [FW-1:0]             fill_next;
    logic                      filling;
    logic                      fill_res_reg;

    // division
    logic                      neg_reg;
    logic [SW-1:0]             abs_reg;
    logic [SW-1:0]             q0_reg;
    logic [2*SW-1:0]           prod;
    logic [2*SW-1:0]           back_full;
    logic [SW-1:0]             rem;
    logic [SW-1:0]             quot;
    logic [SW-1:0]             quot_signed;
    logic signed [VALUE_W-1:0] mean_reg;

    // search
    logic [CW-1:0]             lo_reg;
    logic [CW-1:0]             hi_reg;     // exclusive upper bound
    logic [CW-1:0]             found_reg;
    logic [CW:0]               span;
    logic [CW-1:0]             mid;
    logic [VALUE_W-1:0]        rd_data;
    logic                      idx_ok;
    logic                      tbl_wr;

    // output register
    logic                      m_valid_reg;
    logic [RANK_W-1:0]         m_rank_reg;
    logic [VALUE_W-1:0]        m_mean_reg;

    assign is_sample = (s_mode == MODE_SAMPLE);

    // window fill and sum update
    assign fill_eff  = s_series_start ? '0 : fill_reg;
    assign filling   = fill_eff < FILL_TOP;
    assign fill_next = filling ? fill_eff + 1'b1 : fill_eff;
    assign sum_next  = sum_reg - SW'(win_reg[WINDOW_LENGTH-1]) + SW'(s_temperature);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg  <= '0;
            fill_reg <= '0;
        end else if (cmd.take && is_sample) begin
            for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
                win_reg[i] <= win_reg[i-1];
            end
            win_reg[0]   <= s_temperature;
            sum_reg      <= sum_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && is_sample) begin
            fill_res_reg <= filling;
        end
    end

    // divide by window length: reciprocal multiply, then one correction
    assign prod      = (2*SW)'(abs_reg) * (2*SW)'(RECIP);
    assign back_full = (2*SW)'(q0_reg) * (2*SW)'(WLEN);
    assign rem       = abs_reg - back_full[SW-1:0];
    assign quot      = (rem >= WLEN) ? q0_reg + 1'b1 : q0_reg;
    assign quot_signed = neg_reg ? (~quot + 1'b1) : quot;

    always_ff @(posedge aclk) begin
        if (cmd.abs_step) begin
            neg_reg <= sum_reg[SW-1];
            abs_reg <= sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        end
        if (cmd.mul_step) begin
            q0_reg <= prod[2*SW-1:SW];
        end
        if (cmd.fix_step) begin
            mean_reg <= quot_signed[VALUE_W-1:0];
        end
    end

    // binary search over the threshold table
    assign span = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid  = span[CW:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            found_reg <= '0;
        end else if (cmd.fix_step) begin
            lo_reg    <= '0;
            hi_reg    <= TOP;
            found_reg <= TOP;
        end else if (cmd.probe_cmp) begin
            if (mean_reg <= $signed(rd_data)) begin
                found_reg <= mid + 1'b1;
                hi_reg    <= mid;
            end else begin
                lo_reg    <= mid + 1'b1;
            end
        end
    end

    assign idx_ok = {1'b0, s_table_index} < 8'(TABLE_ENTRIES);
    assign tbl_wr = cmd.take && !is_sample && idx_ok;

    hspr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (TAW'(s_table_index)),
        .wr_data (s_threshold_value),
        .rd_en   (cmd.probe_rd),
        .rd_addr (mid[TAW-1:0]),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_rank_reg <= fill_res_reg ? RANK_FILLING : RANK_W'(found_reg);
            m_mean_reg <= fill_res_reg ? '0 : mean_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rank        = m_rank_reg;
    assign m_window_mean = m_mean_reg;

    assign stat.sample_mode = is_sample;
    assign stat.filling     = filling;
    assign stat.search_open = lo_reg < hi_reg;
    assign stat.out_full    = m_valid_reg;

    `HSPR_ASSERT(a_fill_range, aclk, aresetn, fill_reg <= FILL_TOP)
    `HSPR_ASSERT(a_push_empty, aclk, aresetn, cmd.push |-> !m_valid_reg)
    `HSPR_ASSERT(a_search_bounds, aclk, aresetn, (lo_reg <= hi_reg) && (hi_reg <= TOP))
    `HSPR_ASSERT(a_rem_range, aclk, aresetn, cmd.fix_step |-> (rem < (WLEN + WLEN)))

endmodule

`default_nettype wire

// File: rtl/heat_stress_percentile_rank.sv
// ----------------------------------------------------------------------------
// heat_stress_percentile_rank
// moving average of temperature samples ranked against a threshold table
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  mode, series_start, table_index,
//                                         threshold_value, temperature
// m_        out        m_valid / m_ready  rank, window_mean
//
// table load transaction: the table ram is written at acceptance
// sample inside the fill phase: acceptance, then output push
// ranked sample: acceptance, sign split, reciprocal multiply, correction,
//   the probe loop (table ram read, then compare) of the binary search,
//   then output push; probes is at most ceil(log2(TABLE_ENTRIES + 1)),
//   6 or 7 at the default table size
// reset: synchronous, active low, clears window, running sum, fill count,
//   sequencer and output valid; the threshold table is not cleared
// a result waiting in the output register does not block the next input
//   transaction; only the push of the following result waits for it
// ----------------------------------------------------------------------------
`default_nettype none

module heat_stress_percentile_rank #(
    parameter int TABLE_ENTRIES = hspr_pkg::TABLE_ENTRIES_DEF,
    parameter int WINDOW_LENGTH = hspr_pkg::WINDOW_LENGTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_mode,
    input  wire logic                                 s_series_start,
    input  wire logic        [hspr_pkg::INDEX_W-1:0]  s_table_index,
    input  wire logic signed [hspr_pkg::VALUE_W-1:0]  s_threshold_value,
    input  wire logic signed [hspr_pkg::VALUE_W-1:0]  s_temperature,
    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [hspr_pkg::RANK_W-1:0]   m_rank,
    output logic signed      [hspr_pkg::VALUE_W-1:0]  m_window_mean
);

    import hspr_pkg::*;

    // command and status between sequencer and datapath
    hspr_cmd_t  cmd;
    hspr_stat_t stat;

    // sequencer: accepts transactions in idle, steps the division and the
    // probe loop, and waits for a free output register before pushing
    hspr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: sample window with running sum, reciprocal divide, table
    // ram with the search bounds, and the output register
    hspr_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_mode            (s_mode),
        .s_series_start    (s_series_start),
        .s_table_index     (s_table_index),
        .s_threshold_value (s_threshold_value),
        .s_temperature     (s_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rank            (m_rank),
        .m_window_mean     (m_window_mean),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

`default_nettype wire

// File: test/hspr_rank_checker.sv
// ----------------------------------------------------------------------------
// hspr_rank_checker
// watches both channels, tracks window and threshold table, checks each rank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hspr_rank_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic                                 s_series_start,
    input  logic        [hspr_pkg::INDEX_W-1:0]  s_table_index,
    input  logic signed [hspr_pkg::VALUE_W-1:0]  s_threshold_value,
    input  logic signed [hspr_pkg::VALUE_W-1:0]  s_temperature,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [hspr_pkg::RANK_W-1:0]   m_rank,
    input  logic signed [hspr_pkg::VALUE_W-1:0]  m_window_mean,
    output int                                   mismatch_count,
    output int                                   results_due
);

    localparam int   TABLE_ENTRIES = hspr_pkg::TABLE_ENTRIES_DEF;
    localparam int   WINDOW_LENGTH = hspr_pkg::WINDOW_LENGTH_DEF;
    localparam logic MODE_LOAD     = hspr_pkg::MODE_LOAD;

    typedef struct {
        logic signed [hspr_pkg::RANK_W-1:0]  rank;
        logic signed [hspr_pkg::VALUE_W-1:0] mean;
    } rank_result_t;

    logic signed [hspr_pkg::VALUE_W-1:0] thresholds [TABLE_ENTRIES];
    logic signed [hspr_pkg::VALUE_W-1:0] sample_hist [WINDOW_LENGTH];
    int           fill_count;
    int           mismatches = 0;
    rank_result_t expected_ranks [$];

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) thresholds[i] = '0;
    end

    // binary search over the table, same probe order whatever the contents
    function automatic int percentile_rank(input int mean);
        int lo;
        int hi;
        int mid;
        int found;
        lo    = 0;
        hi    = TABLE_ENTRIES - 1;
        found = TABLE_ENTRIES;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (mean <= int'(thresholds[mid])) begin
                found = mid + 1;
                hi    = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return found;
    endfunction

    always @(posedge aclk) begin : rank_model
        rank_result_t want;
        int           total;
        int           rank_full;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) sample_hist[i] = '0;
            fill_count = 0;
            expected_ranks.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_mode == MODE_LOAD) begin
                    if (s_table_index < TABLE_ENTRIES)
                        thresholds[s_table_index] = s_threshold_value;
                end else begin
                    if (s_series_start) fill_count = 0;
                    for (int i = WINDOW_LENGTH - 1; i > 0; i--)
                        sample_hist[i] = sample_hist[i-1];
                    sample_hist[0] = s_temperature;
                    if (fill_count < WINDOW_LENGTH - 1) begin
                        fill_count++;
                        want.rank = hspr_pkg::RANK_FILLING;
                        want.mean = '0;
                    end else begin
                        total = 0;
                        for (int i = 0; i < WINDOW_LENGTH; i++) total += sample_hist[i];
                        total     = total / WINDOW_LENGTH;
                        want.mean = total[hspr_pkg::VALUE_W-1:0];
                        rank_full = percentile_rank(total);
                        want.rank = rank_full[hspr_pkg::RANK_W-1:0];
                    end
                    expected_ranks.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_ranks.size() == 0) begin
                    $error("unexpected result: rank %0d, window_mean %0d",
                           m_rank, m_window_mean);
                    mismatches++;
                end else begin
                    want = expected_ranks.pop_front();
                    if (m_rank !== want.rank) begin
                        $error("rank: expected %0d, actual %0d", want.rank, m_rank);
                        mismatches++;
                    end
                    if (m_window_mean !== want.mean) begin
                        $error("window_mean: expected %0d, actual %0d",
                               want.mean, m_window_mean);
                        mismatches++;
                    end
                end
            end
        end
        results_due    <= expected_ranks.size();
        mismatch_count <= mismatches;
    end

endmodule

// File: test/tb_heat_stress_percentile_rank.sv
// ----------------------------------------------------------------------------
// tb_heat_stress_percentile_rank
// stimulus and verdict for the heat stress percentile rank block
// ----------------------------------------------------------------------------
// loads a full threshold table before any ranked sample, runs directed corner
// transactions, then random phases of sample streams, all but the first on a
// fresh table (ramp, unsorted, clustered); a checker beside the block predicts
// every result and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heat_stress_percentile_rank;

    localparam int   TABLE_ENTRIES = hspr_pkg::TABLE_ENTRIES_DEF;
    localparam logic MODE_LOAD     = hspr_pkg::MODE_LOAD;
    localparam logic MODE_SAMPLE   = hspr_pkg::MODE_SAMPLE;
    localparam int   PHASE_COUNT   = 5;
    localparam int   PHASE_ITEMS   = 36;
    // leave room for stray outputs after the longest ranked sample
    localparam int   SETTLE_CYCLES = 60;

    typedef enum int {
        TBL_RAMP,
        TBL_RANDOM,
        TBL_CLUSTER
    } table_style_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel, all known from time zero
    logic                                s_valid           = 1'b0;
    logic                                s_ready;
    logic                                s_mode            = MODE_LOAD;
    logic                                s_series_start    = 1'b0;
    logic        [hspr_pkg::INDEX_W-1:0] s_table_index     = '0;
    logic signed [hspr_pkg::VALUE_W-1:0] s_threshold_value = '0;
    logic signed [hspr_pkg::VALUE_W-1:0] s_temperature     = '0;

    // result channel
    logic                                m_valid;
    logic                                m_ready           = 1'b0;
    logic signed [hspr_pkg::RANK_W-1:0]  m_rank;
    logic signed [hspr_pkg::VALUE_W-1:0] m_window_mean;

    int mismatch_count;
    int results_due;

    // sender burst bookkeeping
    int burst_left = 0;
    // value near the middle of the current table, steers sample levels
    int table_mid  = 0;

    // receiver stall pattern state
    int ready_style = 0;
    int style_left  = 0;
    int hold_left   = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    heat_stress_percentile_rank i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_series_start    (s_series_start),
        .s_table_index     (s_table_index),
        .s_threshold_value (s_threshold_value),
        .s_temperature     (s_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rank            (m_rank),
        .m_window_mean     (m_window_mean)
    );

    hspr_rank_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_series_start    (s_series_start),
        .s_table_index     (s_table_index),
        .s_threshold_value (s_threshold_value),
        .s_temperature     (s_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rank            (m_rank),
        .m_window_mean     (m_window_mean),
        .mismatch_count    (mismatch_count),
        .results_due       (results_due)
    );

    // receiver: switches between always ready, random drops and long stalls
    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style <= $urandom_range(0, 2);
            style_left  <= $urandom_range(50, 300);
        end else begin
            style_left <= style_left - 1;
        end
        case (ready_style)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (hold_left == 0) begin
                    m_ready   <= ~m_ready;
                    // going low starts a long stall, going high a short window
                    hold_left <= m_ready ? $urandom_range(5, 30) : $urandom_range(1, 6);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("tb_heat_stress_percentile_rank: done, errors");
        $finish;
    end

    // saturate to the signed 16-bit range
    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // one input transaction; valid stays high across back to back transactions
    task automatic send_item(input logic mode, input logic start,
                             input logic [hspr_pkg::INDEX_W-1:0] idx,
                             input logic signed [15:0] thr,
                             input logic signed [15:0] temp);
        int gap;
        if (burst_left == 0) begin
            // a gap of zero lets bursts run together
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_valid           <= 1'b1;
        s_mode            <= mode;
        s_series_start    <= start;
        s_table_index     <= idx;
        s_threshold_value <= thr;
        s_temperature     <= temp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // table write, with don't-care series_start and temperature
    task automatic load_entry(input logic [hspr_pkg::INDEX_W-1:0] idx,
                              input logic signed [15:0] value);
        send_item(MODE_LOAD, 1'($urandom_range(0, 1)), idx, value, 16'($urandom));
    endtask

    // sample, with don't-care index and threshold value
    task automatic sample(input logic start, input logic signed [15:0] temp);
        send_item(MODE_SAMPLE, start, 7'($urandom_range(0, 127)), 16'($urandom), temp);
    endtask

    // rewrites every table entry, so no search ever reads an unwritten one
    task automatic fill_table(input table_style_t style);
        int acc;
        acc = (style == TBL_CLUSTER) ? $urandom_range(0, 40000) - 20000
                                     : $urandom_range(0, 300) - 32768;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            case (style)
                TBL_RAMP: begin
                    load_entry(7'(i), clip16(acc));
                    acc += $urandom_range(0, 1340);
                end
                TBL_CLUSTER: begin
                    // narrow ascending band with plenty of duplicates
                    load_entry(7'(i), clip16(acc));
                    acc += $urandom_range(0, 40);
                end
                default: begin
                    // unsorted contents, search still follows the same probes
                    acc = $urandom_range(0, 65535) - 32768;
                    load_entry(7'(i), acc[15:0]);
                end
            endcase
            if (i == TABLE_ENTRIES / 2) table_mid = acc;
        end
    endtask

    // hold the sender off until the block has delivered everything
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int series_base;
        int r;
        int level;
        logic start;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // whole table first, ranked samples must never see an unloaded entry
        fill_table(TBL_RAMP);

        // ---- directed ----
        // indexes past the table end are dropped
        load_entry(7'd98, 16'sh1234);
        load_entry(7'd127, 16'sh8000);
        // series_start on a load transaction has no effect on the window
        send_item(MODE_LOAD, 1'b1, 7'd0, 16'sh8000, 16'sh7fff);
        send_item(MODE_LOAD, 1'b1, 7'd97, 16'sh7ffe, 16'sh8000);

        // top extreme: seven filling samples, then mean above the last entry
        sample(1'b1, 16'sh7fff);
        repeat (7) sample(1'b0, 16'sh7fff);
        // rolling down to the bottom extreme, ends on rank 1
        repeat (8) sample(1'b0, 16'sh8000);
        // new series flushes the stale window; small negative sums truncate to 0
        sample(1'b1, -16'sd1);
        repeat (7) sample(1'b0, 16'sd0);
        // sum of -9 gives -1, not -2
        sample(1'b0, -16'sd9);

        // ---- random phases ----
        series_base = 0;
        for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
            // let the pipeline empty out now and then before a new table
            if (phase == 2 || phase == 4) drain();
            case (phase)
                1: ;
                2: fill_table(TBL_RANDOM);
                3: fill_table(TBL_CLUSTER);
                4: fill_table(TBL_RAMP);
                default: fill_table(table_style_t'($urandom_range(0, 2)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // in-range rewrite, may leave the table unsorted
                    load_entry(7'($urandom_range(0, TABLE_ENTRIES - 1)), 16'($urandom));
                end else if (r < 9) begin
                    // ignored write past the end of the table
                    load_entry(7'($urandom_range(TABLE_ENTRIES, 127)), 16'($urandom));
                end else begin
                    start = ($urandom_range(0, 23) == 0);
                    if (start) begin
                        series_base = ($urandom_range(0, 1) == 0)
                                      ? table_mid + $urandom_range(0, 400) - 200
                                      : $urandom_range(0, 65535) - 32768;
                    end
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        level = $urandom_range(0, 1) ? 32767 : -32768;
                    else if (r < 3)
                        level = $urandom_range(0, 65535) - 32768;
                    else
                        level = series_base + $urandom_range(0, 4000) - 2000;
                    sample(start, clip16(level));
                end
            end
        end

        // ---- wind down ----
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && results_due == 0) begin
            $display("tb_heat_stress_percentile_rank: done, clean");
        end else begin
            $display("tb_heat_stress_percentile_rank: done, errors");
        end
        $finish;
    end

endmodule
